>>> design/phgs_pkg.sv
// ----------------------------------------------------------------------------
// phgs_pkg
// Shared types, constants and helpers for the peak-hold gain step calculator.
// ----------------------------------------------------------------------------
package phgs_pkg;

    // field widths
    localparam int SAMPLE_BITS = 12;
    localparam int STEP_BITS   = 7;
    localparam int STEP_MAX    = 127;

    // gain formula constants
    localparam int FULL          = (1 << SAMPLE_BITS) - 1;
    localparam int FULL3         = 3 * FULL;
    localparam int PAR_R_OHMS    = 51000;
    localparam int POT_RES_OHMS  = 100000;
    localparam int WIPER_COUNT   = 128;
    localparam int WIPER_OHMS    = POT_RES_OHMS / WIPER_COUNT;

    // datapath widths
    localparam int    S20_W   = $clog2(20 * FULL + 1);
    localparam int    S1040_W = $clog2(1040 * FULL + 1);
    localparam int    DN_W    = $clog2(FULL3 + 1);
    localparam int    DD_W    = $clog2(1040 * FULL - FULL3 + 1);
    localparam longint NUM_MAX = longint'(PAR_R_OHMS) * longint'(FULL3);
    localparam longint DEN_MAX = longint'(WIPER_OHMS) * longint'(1040 * FULL - FULL3);
    localparam int    NUM_W   = $clog2(NUM_MAX + 1);
    localparam int    DEN_W   = $clog2(DEN_MAX + 1);
    localparam int    DIV_W   = DEN_W + STEP_BITS;
    localparam int    QUO_W   = STEP_BITS + 1;
    localparam int    CNT_W   = $clog2(STEP_BITS + 1);

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [STEP_BITS-1:0] STEP_MAX_V = STEP_BITS'(STEP_MAX);

    // input item
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   calibrate;
    } t_item;

    // result item
    typedef struct packed {
        logic [STEP_BITS-1:0]   wiper_step;
        logic                   pot_write;
        logic [SAMPLE_BITS-1:0] peak_level;
    } t_result;

    // classified item handed from front to back
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] level;
        logic                   write;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV
    } t_back_state;

    // clamp a raw quotient to the largest pot step
    function automatic logic [STEP_BITS-1:0] sat_step(input logic [QUO_W-1:0] q);
        logic [STEP_BITS-1:0] r;
        if (q > QUO_W'(STEP_MAX)) begin
            r = STEP_MAX_V;
        end else begin
            r = q[STEP_BITS-1:0];
        end
        return r;
    endfunction

endpackage

>>> design/phgs_front.sv
// ----------------------------------------------------------------------------
// phgs_front
// Accepts samples, tracks the calibration peak and tags new-peak items.
// ----------------------------------------------------------------------------
module phgs_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  phgs_pkg::t_item      i_item,
    input  logic                 i_full,
    output logic                 o_wr,
    output phgs_pkg::t_cmd       o_cmd
);

    logic [phgs_pkg::SAMPLE_BITS-1:0] r_peak;
    logic [phgs_pkg::SAMPLE_BITS-1:0] n_peak;
    logic                             is_peak;

    // new peak only in calibration mode
    assign is_peak = i_item.calibrate && (i_item.sample > r_peak);
    assign o_wr    = i_push && !i_full;

    always_comb begin
        o_cmd.write = is_peak;
        o_cmd.level = is_peak ? i_item.sample : r_peak;
        n_peak      = (o_wr && is_peak) ? i_item.sample : r_peak;
    end

    // peak hold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
        end else begin
            r_peak <= n_peak;
        end
    end

    a_peak_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr && o_cmd.write) |=> (r_peak == $past(i_item.sample)))
        else $error("peak not updated on new peak item");

endmodule

>>> design/phgs_queue.sv
// ----------------------------------------------------------------------------
// phgs_queue
// Short register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module phgs_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  phgs_pkg::t_cmd       i_data,
    output logic                 o_full,
    input  logic                 i_rd,
    output phgs_pkg::t_cmd       o_data,
    output logic                 o_empty
);

    phgs_pkg::t_cmd                r_mem [phgs_pkg::QDEPTH];
    logic [phgs_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [phgs_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [phgs_pkg::QCNT_W-1:0]   r_count;
    logic [phgs_pkg::QPTR_W-1:0]   n_wr_ptr;
    logic [phgs_pkg::QPTR_W-1:0]   n_rd_ptr;
    logic [phgs_pkg::QCNT_W-1:0]   n_count;
    logic                          do_wr;
    logic                          do_rd;

    assign o_full  = (r_count == phgs_pkg::QCNT_W'(phgs_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == phgs_pkg::QPTR_W'(phgs_pkg::QDEPTH - 1)) ?
                       '0 : r_wr_ptr + phgs_pkg::QPTR_W'(1);
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == phgs_pkg::QPTR_W'(phgs_pkg::QDEPTH - 1)) ?
                       '0 : r_rd_ptr + phgs_pkg::QPTR_W'(1);
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + phgs_pkg::QCNT_W'(1);
        end else if (do_rd && !do_wr) begin
            n_count = r_count - phgs_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= phgs_pkg::QCNT_W'(phgs_pkg::QDEPTH))
        else $error("queue count beyond depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_wr && !do_rd) |=> (r_count == $past(r_count) + phgs_pkg::QCNT_W'(1)))
        else $error("queue count did not grow on write");

endmodule

>>> design/phgs_back.sv
// ----------------------------------------------------------------------------
// phgs_back
// Computes the pot step for new peaks with a single restoring divider
// and holds the result item until it is popped.
// ----------------------------------------------------------------------------
module phgs_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  phgs_pkg::t_cmd       i_cmd,
    input  logic                 i_q_empty,
    output logic                 o_q_pop,
    input  logic                 i_pop,
    output logic                 o_empty,
    output phgs_pkg::t_result    o_result
);

    phgs_pkg::t_back_state               r_state;
    phgs_pkg::t_back_state               n_state;
    logic [phgs_pkg::STEP_BITS-1:0]      r_step;
    logic [phgs_pkg::SAMPLE_BITS-1:0]    r_level;
    logic [phgs_pkg::DN_W-1:0]           r_dn;
    logic [phgs_pkg::DD_W-1:0]           r_dd;
    logic [phgs_pkg::NUM_W-1:0]          r_rem;
    logic [phgs_pkg::DEN_W-1:0]          r_den;
    logic [phgs_pkg::QUO_W-1:0]          r_quo;
    logic [phgs_pkg::CNT_W-1:0]          r_cnt;
    logic                                r_out_valid;
    phgs_pkg::t_result                   r_out;

    logic [phgs_pkg::S20_W-1:0]          s20;
    logic [phgs_pkg::S1040_W-1:0]        s1040;
    logic                                is_large;
    logic                                is_tiny;
    logic                                out_free;
    logic                                take;
    logic                                needs_calc;
    logic                                finish_now;
    logic                                div_done;
    logic [phgs_pkg::STEP_BITS-1:0]      step_now;
    logic [phgs_pkg::DIV_W-1:0]          rem_ext;
    logic [phgs_pkg::DIV_W-1:0]          den_sh;
    logic                                ge;
    logic [phgs_pkg::NUM_W-1:0]          rem_nxt;
    logic [phgs_pkg::QUO_W-1:0]          quo_nxt;

    // classify the peak against the two range limits
    always_comb begin
        s20      = phgs_pkg::S20_W'(i_cmd.level) * phgs_pkg::S20_W'(20);
        s1040    = phgs_pkg::S1040_W'(i_cmd.level) * phgs_pkg::S1040_W'(1040);
        is_large = (s20 >= phgs_pkg::S20_W'(phgs_pkg::FULL3));
        is_tiny  = (s1040 <= phgs_pkg::S1040_W'(phgs_pkg::FULL3));
    end

    // one restoring division step
    always_comb begin
        rem_ext = phgs_pkg::DIV_W'(r_rem);
        den_sh  = phgs_pkg::DIV_W'(r_den) << r_cnt;
        ge      = (rem_ext >= den_sh);
        rem_nxt = ge ? phgs_pkg::NUM_W'(rem_ext - den_sh) : r_rem;
        quo_nxt = r_quo | (phgs_pkg::QUO_W'(ge) << r_cnt);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            phgs_pkg::S_IDLE: begin
                if (needs_calc) begin
                    n_state = phgs_pkg::S_MUL;
                end
            end
            phgs_pkg::S_MUL: begin
                n_state = phgs_pkg::S_DIV;
            end
            phgs_pkg::S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = phgs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = phgs_pkg::S_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        out_free   = !r_out_valid || i_pop;
        take       = 1'b0;
        div_done   = 1'b0;
        case (r_state)
            phgs_pkg::S_IDLE: begin
                take = !i_q_empty && out_free;
            end
            phgs_pkg::S_DIV: begin
                div_done = (r_cnt == '0);
            end
            default: begin
                take     = 1'b0;
                div_done = 1'b0;
            end
        endcase
        needs_calc = take && i_cmd.write && !is_large && !is_tiny;
        finish_now = take && !needs_calc;
        o_q_pop    = take;
        if (!i_cmd.write) begin
            step_now = r_step;
        end else if (is_large) begin
            step_now = '0;
        end else begin
            step_now = phgs_pkg::STEP_MAX_V;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= phgs_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            r_state <= n_state;
            if (finish_now || div_done) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (finish_now && i_cmd.write) begin
                r_step <= step_now;
            end else if (div_done) begin
                r_step <= phgs_pkg::sat_step(quo_nxt);
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_level <= i_cmd.level;
            r_dn    <= phgs_pkg::DN_W'(phgs_pkg::S20_W'(phgs_pkg::FULL3) - s20);
            r_dd    <= phgs_pkg::DD_W'(s1040 - phgs_pkg::S1040_W'(phgs_pkg::FULL3));
        end
        if (r_state == phgs_pkg::S_MUL) begin
            r_rem <= phgs_pkg::NUM_W'(r_dn) * phgs_pkg::NUM_W'(phgs_pkg::PAR_R_OHMS);
            r_den <= phgs_pkg::DEN_W'(r_dd) * phgs_pkg::DEN_W'(phgs_pkg::WIPER_OHMS);
            r_quo <= '0;
            r_cnt <= phgs_pkg::CNT_W'(phgs_pkg::STEP_BITS);
        end else if (r_state == phgs_pkg::S_DIV) begin
            r_rem <= rem_nxt;
            r_quo <= quo_nxt;
            r_cnt <= r_cnt - phgs_pkg::CNT_W'(1);
        end
        if (finish_now) begin
            r_out.wiper_step <= step_now;
            r_out.pot_write  <= i_cmd.write;
            r_out.peak_level <= i_cmd.level;
        end else if (div_done) begin
            r_out.wiper_step <= phgs_pkg::sat_step(quo_nxt);
            r_out.pot_write  <= 1'b1;
            r_out.peak_level <= r_level;
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> !i_q_empty)
        else $error("dequeue from empty queue");

    a_busy_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != phgs_pkg::S_IDLE) |-> !o_q_pop)
        else $error("item taken while divider busy");

    a_mul_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == phgs_pkg::S_MUL) |=>
            ((r_state == phgs_pkg::S_DIV) && (r_cnt == phgs_pkg::CNT_W'(phgs_pkg::STEP_BITS))))
        else $error("divider not started after multiply");

    a_div_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |=> (!o_empty && o_result.pot_write))
        else $error("division result not presented");

endmodule

>>> design/peak_hold_gain_step_calc.sv
// ----------------------------------------------------------------------------
// peak_hold_gain_step_calc
// Peak-hold gain step calculator with queued front and divider back end.
// ----------------------------------------------------------------------------
// Each pushed sample gives exactly one result item, in order. In calibration
// mode a sample above the held peak becomes the new peak and the pot step
// floor(51000*(3*FULL-20s)/(781*(1040s-3*FULL))) is recomputed, saturated to
// 127 for tiny peaks or large quotients and 0 for peaks at or above 615.
// The front puts one sample per cycle into a two-entry queue until it is full.
// The back finishes an item that sets no computed step as it takes it; a new
// peak inside the computed range goes through classify, one constant multiply
// and eight restoring division steps; that divider sets the sustained rate.
// A finished result waits in an output register; the back takes no new item
// until it is popped, while the front goes on filling the queue until full.
// ----------------------------------------------------------------------------
module peak_hold_gain_step_calc (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  phgs_pkg::t_item      i_item,
    input  logic                 pop,
    output logic                 empty,
    output phgs_pkg::t_result    o_result
);

    logic             q_wr;
    phgs_pkg::t_cmd   q_wdata;
    logic             q_rd;
    phgs_pkg::t_cmd   q_rdata;
    logic             q_empty;

    // sample intake and peak tracking
    phgs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .i_full  (full),
        .o_wr    (q_wr),
        .o_cmd   (q_wdata)
    );

    // decoupling queue
    phgs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  (q_wdata),
        .o_full  (full),
        .i_rd    (q_rd),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    // step computation and result register
    phgs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (q_rdata),
        .i_q_empty (q_empty),
        .o_q_pop   (q_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule

>>> test/gain_step_checker.sv
// ----------------------------------------------------------------------------
// gain_step_checker
// Watches both queue ports of the peak-hold gain step calculator, keeps its
// own peak and step state, and compares every popped result field by field
// with the next result still due.
// ----------------------------------------------------------------------------
module gain_step_checker
    import phgs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  logic    i_full,
    input  t_item   i_item,
    input  logic    i_pop,
    input  logic    i_empty,
    input  t_result i_result,
    output int      o_fail_count,
    output int      o_pending,
    output int      o_checked,
    output int      o_new_peaks,
    output int      o_saturated
);
    timeunit 1ns;
    timeprecision 1ps;

    // divider resistor and ohms per wiper step of the gain network
    localparam longint DIVIDER_OHMS      = 51000;
    localparam longint POT_OHMS_PER_STEP = 100000 / 128;
    localparam int     MAX_PRINTED       = 20;

    logic [SAMPLE_BITS-1:0] held_peak;
    logic [STEP_BITS-1:0]   held_step;
    t_result                results_due_q[$];

    // wiper step that brings peak s up to the comparator reference
    function automatic logic [STEP_BITS-1:0] step_for_peak(input logic [SAMPLE_BITS-1:0] s);
        longint full3;
        longint num;
        longint den;
        longint q;
        full3 = 3 * ((longint'(1) << SAMPLE_BITS) - 1);
        // peak already at or above the reference, no gain needed
        if (20 * longint'(s) >= full3) begin
            return '0;
        end
        // denominator zero or negative for tiny peaks
        if (1040 * longint'(s) <= full3) begin
            return STEP_BITS'(STEP_MAX);
        end
        num = DIVIDER_OHMS * (full3 - 20 * longint'(s));
        den = POT_OHMS_PER_STEP * (1040 * longint'(s) - full3);
        q   = num / den;
        if (q > longint'(STEP_MAX)) begin
            q = longint'(STEP_MAX);
        end
        return STEP_BITS'(q);
    endfunction

    // one line per mismatch, printing capped, counting not
    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (o_fail_count < MAX_PRINTED) begin
            $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
        end
        o_fail_count++;
    endtask

    // track accepted items and check accepted results
    always @(posedge i_clk) begin
        t_result due;
        t_result want;
        if (!i_rst_n) begin
            held_peak = '0;
            held_step = '0;
            results_due_q.delete();
        end else begin
            // result side first, so a result can never match its own item
            if (i_pop && !i_empty) begin
                o_checked++;
                if (results_due_q.size() == 0) begin
                    report_mismatch("result with nothing due",
                                    longint'(i_result.peak_level), -1);
                end else begin
                    want = results_due_q.pop_front();
                    if (i_result.wiper_step !== want.wiper_step) begin
                        report_mismatch("wiper_step", longint'(i_result.wiper_step),
                                        longint'(want.wiper_step));
                    end
                    if (i_result.pot_write !== want.pot_write) begin
                        report_mismatch("pot_write", longint'(i_result.pot_write),
                                        longint'(want.pot_write));
                    end
                    if (i_result.peak_level !== want.peak_level) begin
                        report_mismatch("peak_level", longint'(i_result.peak_level),
                                        longint'(want.peak_level));
                    end
                end
            end
            // a calibration sample above the held peak recomputes the step
            if (i_push && !i_full) begin
                due.pot_write = 1'b0;
                if (i_item.calibrate && i_item.sample > held_peak) begin
                    held_peak     = i_item.sample;
                    held_step     = step_for_peak(i_item.sample);
                    due.pot_write = 1'b1;
                    o_new_peaks++;
                    if (held_step == STEP_BITS'(STEP_MAX)) begin
                        o_saturated++;
                    end
                end
                due.wiper_step = held_step;
                due.peak_level = held_peak;
                results_due_q.push_back(due);
            end
        end
        o_pending <= results_due_q.size();
    end

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the peak-hold gain step calculator: directed corner samples,
// then a slowly rising calibration peak through the whole computed step
// range mixed with working-mode and below-peak samples, with random stalls
// on both queue ports. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import phgs_pkg::*;

    // highest peak that still needs gain; one above it gives step zero
    localparam int LAST_GAIN_LEVEL = 614;
    localparam int N_RANDOM        = 1925;
    localparam int QUIET_TAIL      = 150;
    localparam int PAUSE_AT        = 900;
    localparam int SETTLE_CYCLES   = 24;
    localparam int LIMIT_CYCLES    = 200000;

    logic    i_clk;
    logic    i_rst_n;
    logic    push;
    logic    full;
    t_item   item;
    logic    pop;
    logic    empty;
    t_result result;

    int fail_count;
    int pending;
    int checked;
    int new_peaks;
    int saturated;

    logic [SAMPLE_BITS-1:0] walk_peak = '0;
    bit                     quiet     = 1'b0;
    int                     cycles    = 0;

    peak_hold_gain_step_calc DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (item),
        .pop      (pop),
        .empty    (empty),
        .o_result (result)
    );

    gain_step_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_item       (item),
        .i_pop        (pop),
        .i_empty      (empty),
        .i_result     (result),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_new_peaks  (new_peaks),
        .o_saturated  (saturated)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("watchdog expired after %0d cycles, %0d results still due", cycles, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: pop with random stall bursts, steady pop once quiet
    initial begin
        int stall_left;
        stall_left = 0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!quiet && stall_left == 0 && $urandom_range(0, 5) == 0) begin
                stall_left = int'($urandom_range(1, 4));
            end
            if (!quiet && stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // hold push high until the item is taken
    task automatic send_item(input logic cal, input logic [SAMPLE_BITS-1:0] s);
        push <= 1'b1;
        item <= '{sample: s, calibrate: cal};
        do @(posedge i_clk); while (full);
        if (cal && s > walk_peak) begin
            walk_peak = s;
        end
    endtask

    // random idle burst on the input side
    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // wait until every due result has been popped
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int                     n;
        int                     roll;
        logic [SAMPLE_BITS-1:0] s;
        push    <= 1'b0;
        item    <= '0;
        i_rst_n <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: working mode, not above peak, tiny peaks, overlarge quotient
        send_item(1'b0, 12'd4095);
        send_item(1'b0, 12'd0);
        send_item(1'b1, 12'd0);
        send_item(1'b1, 12'd1);
        send_item(1'b1, 12'd1);
        send_item(1'b0, 12'hAAA);
        send_item(1'b1, 12'd11);
        send_item(1'b1, 12'd12);
        send_item(1'b1, 12'd5);
        send_item(1'b0, 12'h555);
        send_item(1'b1, 12'd17);
        send_item(1'b1, 12'd18);
        send_item(1'b1, 12'd19);
        send_item(1'b0, 12'd4095);
        send_item(1'b1, 12'd40);
        send_item(1'b1, 12'd39);

        // random: peak creeps up through the computed range among noise
        for (n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - QUIET_TAIL) begin
                quiet = 1'b1;
            end
            if (n == PAUSE_AT) begin
                drain();
            end
            sender_gap();
            roll = int'($urandom_range(0, 99));
            if (roll < 25 && walk_peak < LAST_GAIN_LEVEL) begin
                // new peak, mostly one code up
                s = SAMPLE_BITS'(walk_peak +
                    (($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 32'd1));
                if (s > LAST_GAIN_LEVEL) begin
                    s = SAMPLE_BITS'(LAST_GAIN_LEVEL);
                end
                send_item(1'b1, s);
            end else if (roll < 55) begin
                send_item(1'b1, SAMPLE_BITS'($urandom_range(0, walk_peak)));
            end else if (roll < 62) begin
                send_item(1'b1, walk_peak);
            end else begin
                send_item(1'b0, SAMPLE_BITS'($urandom_range(0, 4095)));
            end
        end

        // directed top end: last gain level, no gain needed, full scale
        send_item(1'b1, SAMPLE_BITS'(LAST_GAIN_LEVEL));
        send_item(1'b1, SAMPLE_BITS'(LAST_GAIN_LEVEL + 1));
        send_item(1'b1, 12'd4094);
        send_item(1'b1, 12'd4095);
        send_item(1'b1, 12'd4095);
        send_item(1'b0, 12'd0);
        send_item(1'b1, 12'd0);

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("checked %0d results over %0d cycles; %0d new peaks, %0d at saturated step",
                 checked, cycles, new_peaks, saturated);
        $display("calibration peak walked up to %0d, %0d mismatches", walk_peak, fail_count);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
design/phgs_pkg.sv
design/phgs_front.sv
design/phgs_queue.sv
design/phgs_back.sv
design/peak_hold_gain_step_calc.sv
test/gain_step_checker.sv
test/tb.sv
